FILE: sv/bdl_pkg.sv
// shared constants, types and register codes for the button debounce block
package bdl_pkg;

  // block geometry
  localparam int BUTTON_COUNT   = 4;
  localparam int TICK_WIDTH     = 32;
  localparam int CODE_WIDTH     = $clog2(BUTTON_COUNT);
  localparam int LIMIT_WIDTH    = 16;
  localparam int COUNT_WIDTH    = LIMIT_WIDTH + 1;
  localparam int DEBOUNCE_WIDTH = 32;
  localparam int CMP_WIDTH      = (TICK_WIDTH > DEBOUNCE_WIDTH) ? TICK_WIDTH : DEBOUNCE_WIDTH;

  // register port
  localparam int APB_DATA_WIDTH  = 32;
  localparam int APB_ADDR_WIDTH  = 3;
  localparam int REG_INDEX_WIDTH = APB_ADDR_WIDTH - 2;

  typedef logic [REG_INDEX_WIDTH-1:0] reg_index_t;

  localparam reg_index_t REG_DEBOUNCE_TICKS = reg_index_t'(0);
  localparam reg_index_t REG_LOCKOUT_LIMIT  = reg_index_t'(1);

  localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = DEBOUNCE_WIDTH'(150);
  localparam logic [LIMIT_WIDTH-1:0]    LIMIT_RESET    = LIMIT_WIDTH'(5000);

  // one polling word held in the input register
  typedef struct packed {
    logic [BUTTON_COUNT-1:0] pressed;
    logic [TICK_WIDTH-1:0]   now;
  } step_t;

  // one result word
  typedef struct packed {
    logic                    event_valid;
    logic [CODE_WIDTH-1:0]   event_code;
    logic [BUTTON_COUNT-1:0] lockout_mask;
  } result_t;

  // control from the judge to the lockout counters
  typedef struct packed {
    logic                    step;
    logic [BUTTON_COUNT-1:0] start;
  } lock_ctrl_t;

  // lockout status: active_mid after this step's counting, before any restart; mask after restarts
  typedef struct packed {
    logic [BUTTON_COUNT-1:0] active_mid;
    logic [BUTTON_COUNT-1:0] mask;
  } lock_stat_t;

endpackage

FILE: sv/bdl_lockout.sv
// per-button lockout counters, all advanced in parallel once per step
module bdl_lockout (
  input  logic                             clk,
  input  logic                             rst,
  input  bdl_pkg::lock_ctrl_t              ctrl,
  input  logic [bdl_pkg::LIMIT_WIDTH-1:0]  limit,
  output bdl_pkg::lock_stat_t              stat
);

  logic [bdl_pkg::BUTTON_COUNT-1:0] active;
  logic [bdl_pkg::BUTTON_COUNT-1:0] active_next;
  logic [bdl_pkg::COUNT_WIDTH-1:0]  count      [bdl_pkg::BUTTON_COUNT];
  logic [bdl_pkg::COUNT_WIDTH-1:0]  count_next [bdl_pkg::BUTTON_COUNT];
  logic [bdl_pkg::COUNT_WIDTH-1:0]  count_inc  [bdl_pkg::BUTTON_COUNT];
  logic [bdl_pkg::COUNT_WIDTH-1:0]  limit_x;

  // count up, end lockouts past the limit, then apply restarts
  always_comb begin
    limit_x = bdl_pkg::COUNT_WIDTH'(limit);
    for (int i = 0; i < bdl_pkg::BUTTON_COUNT; i++) begin
      count_inc[i] = count[i] + bdl_pkg::COUNT_WIDTH'(1);
      if (active[i]) begin
        count_next[i]           = count_inc[i];
        stat.active_mid[i]      = !(count_inc[i] > limit_x);
      end else begin
        count_next[i]           = count[i];
        stat.active_mid[i]      = 1'b0;
      end
      active_next[i] = stat.active_mid[i];
      if (ctrl.start[i]) begin
        count_next[i]  = '0;
        active_next[i] = 1'b1;
      end
    end
    stat.mask = active_next;
  end

  // counter state
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      for (int i = 0; i < bdl_pkg::BUTTON_COUNT; i++) begin
        count[i] <= '0;
      end
    end else if (ctrl.step) begin
      active <= active_next;
      for (int i = 0; i < bdl_pkg::BUTTON_COUNT; i++) begin
        count[i] <= count_next[i];
      end
    end
  end

endmodule

FILE: sv/bdl_judge.sv
// arm, latch and judge logic: picks a press, waits out the bounce, reports
module bdl_judge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  bdl_pkg::step_t                      word,
  input  logic [bdl_pkg::DEBOUNCE_WIDTH-1:0]  debounce,
  input  bdl_pkg::lock_stat_t                 lock_stat,
  output logic [bdl_pkg::BUTTON_COUNT-1:0]    start,
  output bdl_pkg::result_t                    result
);

  logic                             armed;
  logic                             armed_next;
  logic [bdl_pkg::CODE_WIDTH-1:0]   sel;
  logic [bdl_pkg::CODE_WIDTH-1:0]   sel_next;
  logic [bdl_pkg::TICK_WIDTH-1:0]   press_time;
  logic [bdl_pkg::TICK_WIDTH-1:0]   press_time_next;
  logic [bdl_pkg::TICK_WIDTH-1:0]   elapsed;
  logic                             due;
  logic                             found;
  logic [bdl_pkg::CODE_WIDTH-1:0]   idx;

  // priority pick, lowest index wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = bdl_pkg::BUTTON_COUNT - 1; i >= 0; i--) begin
      if (word.pressed[i]) begin
        found = 1'b1;
        idx   = bdl_pkg::CODE_WIDTH'(i);
      end
    end
  end

  // wrapping elapsed time against the debounce interval
  always_comb begin
    elapsed = word.now - press_time;
    due     = bdl_pkg::CMP_WIDTH'(elapsed) > bdl_pkg::CMP_WIDTH'(debounce);
  end

  // latch when armed, judge when the interval has passed
  always_comb begin
    armed_next         = armed;
    sel_next           = sel;
    press_time_next    = press_time;
    start              = '0;
    result.event_valid = 1'b0;
    result.event_code  = '0;
    if (armed) begin
      if (found) begin
        armed_next      = 1'b0;
        sel_next        = idx;
        press_time_next = word.now;
      end
    end else if (due) begin
      if (!word.pressed[sel] && !lock_stat.active_mid[sel]) begin
        result.event_valid = 1'b1;
        result.event_code  = sel;
        start[sel]         = 1'b1;
      end
      armed_next = 1'b1;
    end
    result.lockout_mask = lock_stat.mask;
  end

  // arm state, selected button and press time
  always_ff @(posedge clk) begin
    if (rst) begin
      armed      <= 1'b1;
      sel        <= '0;
      press_time <= '0;
    end else if (step) begin
      armed      <= armed_next;
      sel        <= sel_next;
      press_time <= press_time_next;
    end
  end

endmodule

FILE: sv/button_debounce_with_lockout_unit.sv
// top level: register port, input register, step logic and result register
//
//  channel  handshake                        word
//  input    in_valid / in_ready              call/water/order/bill_pressed, now_ticks
//  output   out_valid / out_ready            event_valid, event_code, lockout_mask
//  config   psel/penable/pwrite/pready       paddr, pwdata, prdata
//
// one word per cycle while the output is not stalled; a taken word reaches the output
// through the input register, then one pass through the step logic into the result register
// the step logic updates arm state and the lockout counters as the word moves on
// a stalled output holds its word; the input register still fills behind it
// rst is synchronous: armed, no lockouts, registers at their reset values
module button_debounce_with_lockout_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                call_pressed,
  input  logic                                water_pressed,
  input  logic                                order_pressed,
  input  logic                                bill_pressed,
  input  logic [bdl_pkg::TICK_WIDTH-1:0]      now_ticks,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                event_valid,
  output logic [bdl_pkg::CODE_WIDTH-1:0]      event_code,
  output logic [bdl_pkg::BUTTON_COUNT-1:0]    lockout_mask,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bdl_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [bdl_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [bdl_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                pready
);

  logic [bdl_pkg::DEBOUNCE_WIDTH-1:0] debounce_ticks;
  logic [bdl_pkg::LIMIT_WIDTH-1:0]    lockout_limit;
  bdl_pkg::reg_index_t                reg_index;
  logic                               reg_write;

  logic                               s1_valid;
  bdl_pkg::step_t                     s1_word;
  logic                               advance;
  logic                               in_take;

  bdl_pkg::lock_ctrl_t                lock_ctrl;
  bdl_pkg::lock_stat_t                lock_stat;
  logic [bdl_pkg::BUTTON_COUNT-1:0]   start;
  bdl_pkg::result_t                   step_result;
  bdl_pkg::result_t                   out_word;

  // register port decode
  assign pready    = 1'b1;
  assign reg_index = paddr[bdl_pkg::APB_ADDR_WIDTH-1:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_index)
      bdl_pkg::REG_DEBOUNCE_TICKS: prdata = bdl_pkg::APB_DATA_WIDTH'(debounce_ticks);
      bdl_pkg::REG_LOCKOUT_LIMIT:  prdata = bdl_pkg::APB_DATA_WIDTH'(lockout_limit);
      default:                     prdata = '0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= bdl_pkg::DEBOUNCE_RESET;
      lockout_limit  <= bdl_pkg::LIMIT_RESET;
    end else if (reg_write) begin
      case (reg_index)
        bdl_pkg::REG_DEBOUNCE_TICKS: debounce_ticks <= pwdata[bdl_pkg::DEBOUNCE_WIDTH-1:0];
        bdl_pkg::REG_LOCKOUT_LIMIT:  lockout_limit  <= pwdata[bdl_pkg::LIMIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // flow control between input register and result register
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign in_take  = in_valid && in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word.pressed <= bdl_pkg::BUTTON_COUNT'({bill_pressed, order_pressed,
                                                 water_pressed, call_pressed});
      s1_word.now     <= now_ticks;
    end
  end

  // step logic
  assign lock_ctrl.step  = advance;
  assign lock_ctrl.start = start;

  bdl_lockout u_lockout (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (lock_ctrl),
    .limit (lockout_limit),
    .stat  (lock_stat)
  );

  bdl_judge u_judge (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .word      (s1_word),
    .debounce  (debounce_ticks),
    .lock_stat (lock_stat),
    .start     (start),
    .result    (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= step_result;
    end
  end

  assign event_valid  = out_word.event_valid;
  assign event_code   = out_word.event_code;
  assign lockout_mask = out_word.lockout_mask;

  // a reported button always shows as locked out in the same word
  a_event_locks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_valid) |-> lockout_mask[event_code])
    else $error("reported button not marked as locked out");

  // a word without an event carries code zero
  a_idle_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !event_valid) |-> (event_code == '0))
    else $error("event code set without an event");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

endmodule
